// ===== rtl/core/pno_pkg.sv =====
// Package: permutation table, saturating fixed-point helpers and register indexes.
`timescale 1ns / 1ps
package pno_pkg;

    localparam int PERM_SIZE = 256;
    localparam int IDX_W     = 8;

    localparam logic [IDX_W-1:0] REG_OVERALL_WEIGHT = 8'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET_SEED    = 8'd1;
    localparam logic [IDX_W-1:0] REG_BASE_FREQUENCY = 8'd2;
    localparam logic [IDX_W-1:0] REG_BASE_STRENGTH  = 8'd3;
    localparam logic [IDX_W-1:0] REG_DETAIL_WEIGHT  = 8'd4;
    localparam logic [IDX_W-1:0] REG_ROUGHNESS      = 8'd5;

    typedef logic signed [31:0] q_t;
    typedef logic [7:0]         hash_t;

    localparam hash_t PERM_ROM [PERM_SIZE] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic q_t sat64(input logic signed [63:0] v);
        q_t r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = q_t'(v[31:0]);
        return r;
    endfunction

    function automatic q_t sat33(input logic signed [32:0] v);
        q_t r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
            r = q_t'(v[31:0]);
        return r;
    endfunction

    function automatic q_t sadd(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic q_t ssub(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

    function automatic q_t mulq(input q_t a, input q_t b, input int frac);
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = 64'(a) * 64'(b);
        s = p >>> frac;
        return sat64(s);
    endfunction

    function automatic q_t lerp(input q_t t, input q_t a, input q_t b, input int frac);
        return sadd(a, mulq(t, ssub(b, a), frac));
    endfunction

    function automatic q_t grad(input logic [3:0] h, input q_t x, input q_t y, input q_t z);
        q_t u;
        q_t v;
        u = (h < 4'd8) ? x : y;
        if (h < 4'd4)
            v = y;
        else if (h == 4'd12 || h == 4'd14)
            v = x;
        else
            v = z;
        if (h[0])
            u = -u;
        if (h[1])
            v = -v;
        return u + v;
    endfunction

endpackage

// ===== rtl/core/pno_time_if.sv =====
// Interface: input channel carrying one time sample per word.
`timescale 1ns / 1ps
interface pno_time_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_sample;

    modport source (output valid, output time_sample, input ready);
    modport sink   (input valid, input time_sample, output ready);
endinterface

// ===== rtl/core/pno_noise_if.sv =====
// Interface: output channel carrying one noise value per word.
`timescale 1ns / 1ps
interface pno_noise_if;
    logic        valid;
    logic        ready;
    logic [31:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// ===== rtl/core/pno_cfg_if.sv =====
// Interface: configuration write channel, register index and write data.
`timescale 1ns / 1ps
interface pno_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] value;

    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface

// ===== rtl/core/pno_noise.sv =====
// Eight-stage pipelined 3D gradient noise evaluator at a diagonal lattice point.
`timescale 1ns / 1ps
module pno_noise
    import pno_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [FRAC_BITS+7:0] coord,
    output q_t                   n
);

    localparam q_t ONE_Q     = q_t'(64'sd1 <<< FRAC_BITS);
    localparam q_t FIFTEEN_Q = q_t'(64'sd15 <<< FRAC_BITS);
    localparam q_t TEN_Q     = q_t'(64'sd10 <<< FRAC_BITS);

    q_t         f0_1_reg, f0_2_reg, f0_3_reg, f0_4_reg;
    q_t         m1_reg, q1_reg, q2_reg;
    q_t         w4_reg, w5_reg, w6_reg, w7_reg;
    hash_t      c1_reg;
    hash_t      a_reg, b_reg;
    hash_t      aa_reg, ba_reg, ab_reg, bb_reg;
    logic [3:0] h_reg [8];
    logic [3:0] hd_reg [8];
    q_t         g_reg [8];
    q_t         x_reg [4];
    q_t         y0_reg, y1_reg, n_reg;

    q_t    f0_in;
    q_t    f0x6;
    hash_t c_in;
    q_t    f1_4;

    assign c_in  = coord[FRAC_BITS+7:FRAC_BITS];
    assign f0_in = q_t'({{(32-FRAC_BITS){1'b0}}, coord[FRAC_BITS-1:0]});
    assign f0x6  = (f0_in <<< 2) + (f0_in <<< 1);
    assign f1_4  = f0_4_reg - ONE_Q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_1_reg <= f0_in;
            c1_reg   <= c_in;
            m1_reg   <= mulq(f0_in, ssub(f0x6, FIFTEEN_Q), FRAC_BITS);
            a_reg    <= PERM_ROM[c_in] + c_in;
            b_reg    <= PERM_ROM[c_in + 8'd1] + c_in;

            f0_2_reg <= f0_1_reg;
            q1_reg   <= mulq(f0_1_reg, sadd(m1_reg, TEN_Q), FRAC_BITS);
            aa_reg   <= PERM_ROM[a_reg] + c1_reg;
            ba_reg   <= PERM_ROM[b_reg] + c1_reg;
            ab_reg   <= PERM_ROM[a_reg + 8'd1] + c1_reg;
            bb_reg   <= PERM_ROM[b_reg + 8'd1] + c1_reg;

            f0_3_reg <= f0_2_reg;
            q2_reg   <= mulq(f0_2_reg, q1_reg, FRAC_BITS);
            h_reg[0] <= PERM_ROM[aa_reg][3:0];
            h_reg[1] <= PERM_ROM[ba_reg][3:0];
            h_reg[2] <= PERM_ROM[ab_reg][3:0];
            h_reg[3] <= PERM_ROM[bb_reg][3:0];
            h_reg[4] <= PERM_ROM[aa_reg + 8'd1][3:0];
            h_reg[5] <= PERM_ROM[ba_reg + 8'd1][3:0];
            h_reg[6] <= PERM_ROM[ab_reg + 8'd1][3:0];
            h_reg[7] <= PERM_ROM[bb_reg + 8'd1][3:0];

            f0_4_reg <= f0_3_reg;
            w4_reg   <= mulq(f0_3_reg, q2_reg, FRAC_BITS);
            hd_reg   <= h_reg;

            g_reg[0] <= grad(hd_reg[0], f0_4_reg, f0_4_reg, f0_4_reg);
            g_reg[1] <= grad(hd_reg[1], f1_4,     f0_4_reg, f0_4_reg);
            g_reg[2] <= grad(hd_reg[2], f0_4_reg, f1_4,     f0_4_reg);
            g_reg[3] <= grad(hd_reg[3], f1_4,     f1_4,     f0_4_reg);
            g_reg[4] <= grad(hd_reg[4], f0_4_reg, f0_4_reg, f1_4);
            g_reg[5] <= grad(hd_reg[5], f1_4,     f0_4_reg, f1_4);
            g_reg[6] <= grad(hd_reg[6], f0_4_reg, f1_4,     f1_4);
            g_reg[7] <= grad(hd_reg[7], f1_4,     f1_4,     f1_4);
            w5_reg   <= w4_reg;

            x_reg[0] <= lerp(w5_reg, g_reg[0], g_reg[1], FRAC_BITS);
            x_reg[1] <= lerp(w5_reg, g_reg[2], g_reg[3], FRAC_BITS);
            x_reg[2] <= lerp(w5_reg, g_reg[4], g_reg[5], FRAC_BITS);
            x_reg[3] <= lerp(w5_reg, g_reg[6], g_reg[7], FRAC_BITS);
            w6_reg   <= w5_reg;

            y0_reg   <= lerp(w6_reg, x_reg[0], x_reg[1], FRAC_BITS);
            y1_reg   <= lerp(w6_reg, x_reg[2], x_reg[3], FRAC_BITS);
            w7_reg   <= w6_reg;

            n_reg    <= lerp(w7_reg, y0_reg, y1_reg, FRAC_BITS);
        end
    end

    assign n = n_reg;

endmodule

// ===== rtl/core/perlin_noise_two_octave.sv =====
// Top level: two-octave gradient noise over time, pipelined, one word per cycle while dout is not stalled.
//
//  channel | dir | payload                  | handshake
//  cfg     | in  | index[7:0], value[31:0]  | valid/ready, ready always high
//  din     | in  | time_sample[31:0]        | valid/ready
//  dout    | out | noise_value[31:0]        | valid/ready
//
//  One word enters per cycle while dout is not stalled.
//  Stages: input register, coordinate product, four fade products, gradients,
//  three lerp levels and three output weightings, one per stage.
//  rst_n clears the valid chain and sets the configuration registers to their reset values.
//  A stall on dout freezes the whole pipeline; din.ready drops with it.
`timescale 1ns / 1ps
module perlin_noise_two_octave
    import pno_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    pno_cfg_if.sink      cfg,
    pno_time_if.sink     din,
    pno_noise_if.source  dout
);

    localparam int NSTAGE = 13;

    localparam q_t ONE_Q = q_t'(64'sd1 <<< FRAC_BITS);
    localparam q_t K_F1  = q_t'(((64'sd78 <<< FRAC_BITS) + 64'sd500) / 1000);
    localparam q_t K_F2  = q_t'(((64'sd67 <<< FRAC_BITS) + 64'sd500) / 1000);
    localparam q_t K_RGH = q_t'(((64'sd84 <<< FRAC_BITS) + 64'sd500) / 1000);
    localparam q_t K_DET = q_t'(((64'sd33 <<< FRAC_BITS) + 64'sd5) / 10);

    q_t weight_reg, seed_reg, freq_reg, strength_reg, detail_reg, rough_reg;
    q_t rs_reg, rk_reg;

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic              adv;

    q_t t1_reg, f1_reg, f2_reg;
    logic [FRAC_BITS+7:0] c1_reg, c2_reg;
    logic signed [63:0]   p1, p2;
    q_t n1, n2;
    q_t s1_reg, m2_reg, s1d_reg, h_reg, res_reg;

    assign adv      = !vld_reg[NSTAGE-1] || dout.ready;
    assign din.ready = adv;
    assign cfg.ready = 1'b1;
    assign vld_next = {vld_reg[NSTAGE-2:0], din.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg   <= ONE_Q;
            seed_reg     <= '0;
            freq_reg     <= ONE_Q;
            strength_reg <= ONE_Q;
            detail_reg   <= '0;
            rough_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_OVERALL_WEIGHT: weight_reg   <= q_t'(cfg.value);
                REG_OFFSET_SEED:    seed_reg     <= q_t'(cfg.value);
                REG_BASE_FREQUENCY: freq_reg     <= q_t'(cfg.value);
                REG_BASE_STRENGTH:  strength_reg <= q_t'(cfg.value);
                REG_DETAIL_WEIGHT:  detail_reg   <= q_t'(cfg.value);
                REG_ROUGHNESS:      rough_reg    <= q_t'(cfg.value);
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        rs_reg <= sadd(rough_reg, K_RGH);
        rk_reg <= mulq(rs_reg, K_DET, FRAC_BITS);
    end

    assign p1 = 64'(t1_reg) * 64'(f1_reg);
    assign p2 = 64'(t1_reg) * 64'(f2_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg  <= q_t'(din.time_sample);
            f1_reg  <= mulq(freq_reg, K_F1, FRAC_BITS);
            f2_reg  <= sadd(sadd(freq_reg, K_F2), sadd(freq_reg, K_F2));

            c1_reg  <= p1[2*FRAC_BITS+7:FRAC_BITS] + seed_reg[FRAC_BITS+7:0];
            c2_reg  <= p2[2*FRAC_BITS+7:FRAC_BITS] + seed_reg[FRAC_BITS+7:0];

            s1_reg  <= mulq(strength_reg, n1, FRAC_BITS);
            m2_reg  <= mulq(rk_reg, n2, FRAC_BITS);

            s1d_reg <= s1_reg;
            h_reg   <= mulq(detail_reg, m2_reg, FRAC_BITS);

            res_reg <= mulq(weight_reg, sadd(s1d_reg, h_reg), FRAC_BITS);
        end
    end

    pno_noise #(.FRAC_BITS(FRAC_BITS)) u_oct1
    (
        .clk   (clk),
        .en    (adv),
        .coord (c1_reg),
        .n     (n1)
    );

    pno_noise #(.FRAC_BITS(FRAC_BITS)) u_oct2
    (
        .clk   (clk),
        .en    (adv),
        .coord (c2_reg),
        .n     (n2)
    );

    assign dout.valid       = vld_reg[NSTAGE-1];
    assign dout.noise_value = res_reg;

endmodule

// ===== rtl/core/pno_checker.sv =====
// Checker: port-level assertions on the noise block, bound to the top level.
`timescale 1ns / 1ps
module pno_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value))
        else $error("result word changed while stalled");

    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held off with empty output stage");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while pipeline stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration write refused");

endmodule

bind perlin_noise_two_octave pno_checker u_pno_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg.ready),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_value (dout.noise_value)
);
